// File: sv/rgbgl_pkg.sv
// Shared types, constants and gamma tables for the RGB gamma LUT core.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package rgbgl_pkg;

    localparam int unsigned PIX_W   = 8;
    localparam int unsigned FRAC_W  = 3;
    localparam int unsigned SEG_W   = PIX_W - FRAC_W;
    localparam int unsigned IDX_W   = SEG_W + 1;
    localparam int unsigned LVL_W   = 12;
    localparam int unsigned GRN_W   = 11;
    localparam int unsigned SUM_W   = LVL_W + FRAC_W;
    localparam int unsigned TAB_LEN = 33;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } chan_t;

    typedef logic [LVL_W-1:0] level_t;

    // Entry k = round(max * (8k/256)^2.5), max 2048 / 1024 / 4095.
    localparam level_t RED_TAB [TAB_LEN] = '{
        12'd0,    12'd0,    12'd2,    12'd6,    12'd11,   12'd20,   12'd31,
        12'd46,   12'd64,   12'd86,   12'd112,  12'd142,  12'd176,  12'd215,
        12'd259,  12'd308,  12'd362,  12'd421,  12'd486,  12'd556,  12'd632,
        12'd715,  12'd803,  12'd897,  12'd998,  12'd1105, 12'd1219, 12'd1339,
        12'd1467, 12'd1601, 12'd1743, 12'd1892, 12'd2048
    };

    localparam level_t GRN_TAB [TAB_LEN] = '{
        12'd0,    12'd0,    12'd1,    12'd3,    12'd6,    12'd10,   12'd16,
        12'd23,   12'd32,   12'd43,   12'd56,   12'd71,   12'd88,   12'd108,
        12'd130,  12'd154,  12'd181,  12'd211,  12'd243,  12'd278,  12'd316,
        12'd357,  12'd401,  12'd448,  12'd499,  12'd552,  12'd609,  12'd670,
        12'd733,  12'd801,  12'd871,  12'd946,  12'd1024
    };

    localparam level_t BLU_TAB [TAB_LEN] = '{
        12'd0,    12'd1,    12'd4,    12'd11,   12'd23,   12'd40,   12'd62,
        12'd92,   12'd128,  12'd172,  12'd224,  12'd284,  12'd353,  12'd431,
        12'd518,  12'd616,  12'd724,  12'd842,  12'd972,  12'd1112, 12'd1265,
        12'd1429, 12'd1605, 12'd1793, 12'd1995, 12'd2209, 12'd2437, 12'd2678,
        12'd2933, 12'd3202, 12'd3485, 12'd3783, 12'd4095
    };

    function automatic level_t lut_entry(input chan_t ch, input logic [IDX_W-1:0] idx);
        level_t val;
        val = '0;
        unique case (ch)
            CH_RED:   val = RED_TAB[idx];
            CH_GREEN: val = GRN_TAB[idx];
            default:  val = BLU_TAB[idx];
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// File: sv/rgb_gamma_interpolating_lut_core.sv
// Top level of the RGB gamma LUT core: three interpolating lanes and the
// merging output stage. Depends on rgbgl_pkg, rgbgl_lane and rgbgl_merge.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    s_red_in, s_green_in, s_blue_in (8b)
//   m_        out        m_valid/m_ready    m_red_drive (12b), m_green_drive (11b),
//                                           m_blue_drive (12b)
//
// One pixel per cycle unless m_ready stalls the output; a result passes through
// the lookup register in each lane and then the output register.
// Reset (aresetn, synchronous) empties both stages; the tables are constants.
// A stall on m_ready fills the output stage and then the lookup stage before
// s_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module rgb_gamma_interpolating_lut_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [rgbgl_pkg::PIX_W-1:0]   s_red_in,
    input  wire logic [rgbgl_pkg::PIX_W-1:0]   s_green_in,
    input  wire logic [rgbgl_pkg::PIX_W-1:0]   s_blue_in,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [rgbgl_pkg::LVL_W-1:0]   m_red_drive,
    output logic      [rgbgl_pkg::GRN_W-1:0]   m_green_drive,
    output logic      [rgbgl_pkg::LVL_W-1:0]   m_blue_drive
);

    logic                        lane_load;
    logic [rgbgl_pkg::LVL_W-1:0] red_lvl, grn_lvl, blu_lvl;

    rgbgl_lane u_lane_red (
        .aclk  (aclk),
        .chan  (rgbgl_pkg::CH_RED),
        .load  (lane_load),
        .pix   (s_red_in),
        .level (red_lvl)
    );

    rgbgl_lane u_lane_green (
        .aclk  (aclk),
        .chan  (rgbgl_pkg::CH_GREEN),
        .load  (lane_load),
        .pix   (s_green_in),
        .level (grn_lvl)
    );

    rgbgl_lane u_lane_blue (
        .aclk  (aclk),
        .chan  (rgbgl_pkg::CH_BLUE),
        .load  (lane_load),
        .pix   (s_blue_in),
        .level (blu_lvl)
    );

    rgbgl_merge u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .lane_load     (lane_load),
        .red_lvl       (red_lvl),
        .grn_lvl       (grn_lvl),
        .blu_lvl       (blu_lvl),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red_drive   (m_red_drive),
        .m_green_drive (m_green_drive),
        .m_blue_drive  (m_blue_drive)
    );

endmodule

`default_nettype wire

// File: sv/rgbgl_lane.sv
// One color lane: table lookup into a registered stage, then the weighted
// interpolation of the two neighboring entries. Depends on rgbgl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgbgl_lane (
    input  wire logic                          aclk,
    input  wire rgbgl_pkg::chan_t              chan,
    input  wire logic                          load,
    input  wire logic [rgbgl_pkg::PIX_W-1:0]   pix,
    output logic      [rgbgl_pkg::LVL_W-1:0]   level
);

    logic [rgbgl_pkg::LVL_W-1:0]  lo_reg, lo_next;
    logic [rgbgl_pkg::LVL_W-1:0]  hi_reg, hi_next;
    logic [rgbgl_pkg::FRAC_W-1:0] frac_reg;
    logic [rgbgl_pkg::IDX_W-1:0]  seg;
    logic [rgbgl_pkg::FRAC_W:0]   lo_wt;
    logic [rgbgl_pkg::SUM_W:0]    mix;

    assign seg     = {1'b0, pix[rgbgl_pkg::PIX_W-1:rgbgl_pkg::FRAC_W]};
    assign lo_next = rgbgl_pkg::lut_entry(chan, seg);
    assign hi_next = rgbgl_pkg::lut_entry(chan, seg + 1'b1);

    always_ff @(posedge aclk) begin
        if (load) begin
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            frac_reg <= pix[rgbgl_pkg::FRAC_W-1:0];
        end
    end

    // The two weights always sum to eight, so the sum stays below 2^15.
    assign lo_wt = (rgbgl_pkg::FRAC_W + 1)'(1 << rgbgl_pkg::FRAC_W) - {1'b0, frac_reg};
    assign mix   = (rgbgl_pkg::SUM_W + 1)'(lo_reg * lo_wt)
                 + (rgbgl_pkg::SUM_W + 1)'(hi_reg * frac_reg);
    assign level = mix[rgbgl_pkg::FRAC_W +: rgbgl_pkg::LVL_W];

endmodule

`default_nettype wire

// File: sv/rgbgl_merge.sv
// Merging stage: gathers the three lane levels into the output register and
// runs the two-stage valid/ready control. Depends on rgbgl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgbgl_merge (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    output logic                               lane_load,
    input  wire logic [rgbgl_pkg::LVL_W-1:0]   red_lvl,
    input  wire logic [rgbgl_pkg::LVL_W-1:0]   grn_lvl,
    input  wire logic [rgbgl_pkg::LVL_W-1:0]   blu_lvl,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [rgbgl_pkg::LVL_W-1:0]   m_red_drive,
    output logic      [rgbgl_pkg::GRN_W-1:0]   m_green_drive,
    output logic      [rgbgl_pkg::LVL_W-1:0]   m_blue_drive
);

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic out_load;
    logic [rgbgl_pkg::LVL_W-1:0] red_reg, blu_reg;
    logic [rgbgl_pkg::GRN_W-1:0] grn_reg;

    // Each stage takes new data when it is empty or its contents move on.
    assign out_load  = !v2_reg || m_ready;
    assign lane_load = !v1_reg || out_load;
    assign s_ready   = lane_load;
    assign v1_next   = lane_load ? s_valid : v1_reg;
    assign v2_next   = out_load  ? v1_reg  : v2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && v1_reg) begin
            red_reg <= red_lvl;
            grn_reg <= grn_lvl[rgbgl_pkg::GRN_W-1:0];
            blu_reg <= blu_lvl;
        end
    end

    assign m_valid       = v2_reg;
    assign m_red_drive   = red_reg;
    assign m_green_drive = grn_reg;
    assign m_blue_drive  = blu_reg;

endmodule

`default_nettype wire

// File: sv/rgbgl_checker.sv
// Port-level checks for the RGB gamma LUT core, bound to the top level.
// Depends on rgbgl_pkg for widths only.
`timescale 1ns / 1ps
`default_nettype none

module rgbgl_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [rgbgl_pkg::LVL_W-1:0] m_red_drive,
    input wire logic [rgbgl_pkg::GRN_W-1:0] m_green_drive,
    input wire logic [rgbgl_pkg::LVL_W-1:0] m_blue_drive
);

    // A result held back by the sink keeps its value until it transfers.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red_drive)
            && $stable(m_green_drive) && $stable(m_blue_drive))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_red_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_red_drive <= 12'd2048)
        else $error("red drive above table peak");

    a_green_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_green_drive <= 11'd1024)
        else $error("green drive above table peak");

    // With the output draining, the core never refuses a new pixel.
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input blocked while output drains");

endmodule

bind rgb_gamma_interpolating_lut_core rgbgl_checker u_rgbgl_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_red_drive   (m_red_drive),
    .m_green_drive (m_green_drive),
    .m_blue_drive  (m_blue_drive)
);

`default_nettype wire
